/* sv/psfu_pkg.sv */
// ----------------------------------------------------------------------------
// psfu_pkg
// Shared types, codes and constants of the pixel store / upsampler block.
// ----------------------------------------------------------------------------
package psfu_pkg;

    // plane size defaults
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    // cleared pixel: mid gray in 12.4 fixed point
    localparam logic [15:0] CLEAR_VALUE = 16'd2048;

    // item kinds
    localparam logic [1:0] K_LOAD  = 2'd0;
    localparam logic [1:0] K_APPLY = 2'd1;
    localparam logic [1:0] K_READ  = 2'd2;
    localparam logic [1:0] K_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MODE   = 2'd2;

    // datapath operations
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_ACCEPT = 4'd1;
    localparam logic [3:0] OP_CLR    = 4'd2;
    localparam logic [3:0] OP_MUL    = 4'd3;
    localparam logic [3:0] OP_OUT    = 4'd4;
    localparam logic [3:0] OP_D_WR   = 4'd5;
    localparam logic [3:0] OP_F_ACC  = 4'd6;
    localparam logic [3:0] OP_F_WR   = 4'd7;
    localparam logic [3:0] OP_U_INIT = 4'd8;
    localparam logic [3:0] OP_U_ACC  = 4'd9;
    localparam logic [3:0] OP_U_WR   = 4'd10;

    // coordinate source for the address multiplier
    localparam logic [1:0] CS_READ   = 2'd0;
    localparam logic [1:0] CS_DIRECT = 2'd1;
    localparam logic [1:0] CS_TAP    = 2'd2;
    localparam logic [1:0] CS_UP     = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] sample_index;
        logic [7:0] sample_value;
        logic [3:0] block_col;
        logic [3:0] block_row;
        logic [7:0] read_x;
        logic [7:0] read_y;
    } t_item;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] csel;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic f_skip;
        logic f_plane;
        logic clr_last;
        logic d_last;
        logic f_last;
        logic u_last;
        logic tap_last;
        logic out_busy;
    } t_stat;

endpackage

/* sv/psfu_item_if.sv */
// ----------------------------------------------------------------------------
// psfu_item_if
// Input channel: one command item per beat.
// ----------------------------------------------------------------------------
interface psfu_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [5:0] sample_index;
    logic [7:0] sample_value;
    logic [3:0] block_col;
    logic [3:0] block_row;
    logic [7:0] read_x;
    logic [7:0] read_y;

    modport source (
        output valid, kind, sample_index, sample_value, block_col, block_row,
               read_x, read_y,
        input  ready
    );
    modport sink (
        input  valid, kind, sample_index, sample_value, block_col, block_row,
               read_x, read_y,
        output ready
    );
endinterface

/* sv/psfu_result_if.sv */
// ----------------------------------------------------------------------------
// psfu_result_if
// Output channel: one pixel read result per beat.
// ----------------------------------------------------------------------------
interface psfu_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_raw;
    logic [7:0]  pixel_byte;

    modport source (output valid, pixel_raw, pixel_byte, input ready);
    modport sink   (input  valid, pixel_raw, pixel_byte, output ready);
endinterface

/* sv/block_pixel_store_fancy_upsample_unit.sv */
// ----------------------------------------------------------------------------
// block_pixel_store_fancy_upsample_unit
// Image plane store with 1x1 block writes and 2x2 fancy upsampling.
// ----------------------------------------------------------------------------
// One item at a time. A sample load is taken straight from idle; a pixel read
// multiplies the address and reads the plane, and waits to hand out its result
// while the previous result is still waiting; a direct 1x1 apply runs a multiply
// and a write for each of the 64 samples. A 2x2 apply builds the patch, copying
// replicated or sample entries and rebuilding the others from four plane taps,
// then upsamples up to 18x18 pixels, fewer for blocks at the image edge or for
// small images; a block whose corner lies outside the image is dropped. Clear,
// and the pass that follows reset, write MAX_WIDTH*MAX_HEIGHT pixels at one a
// cycle with no item taken. These steps follow from the single plane port
// shared by every read and write, and the one address multiplier.
// ----------------------------------------------------------------------------
module block_pixel_store_fancy_upsample_unit
    import psfu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    psfu_item_if.sink     i_item,
    psfu_result_if.source o_result
);

    t_item w_item;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    // gather the input beat
    assign w_item.kind         = i_item.kind;
    assign w_item.sample_index = i_item.sample_index;
    assign w_item.sample_value = i_item.sample_value;
    assign w_item.block_col    = i_item.block_col;
    assign w_item.block_row    = i_item.block_row;
    assign w_item.read_x       = i_item.read_x;
    assign w_item.read_y       = i_item.read_y;
    assign i_item.ready        = w_in_ready;

    psfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_kind  (i_item.kind),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    psfu_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (o_result)
    );

endmodule

/* sv/psfu_datapath.sv */
// ----------------------------------------------------------------------------
// psfu_datapath
// Plane, sample and patch memories, address multiplier, loop counters,
// accumulator and output register.
// ----------------------------------------------------------------------------
module psfu_datapath
    import psfu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  t_item               i_item,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    psfu_result_if.source       o_result
);

    localparam int PLANE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW         = $clog2(PLANE_SIZE);
    localparam int PW         = (AW >= 16) ? AW + 1 : 17;

    // patch entry source
    localparam logic [2:0] BR_LEFT   = 3'd0;
    localparam logic [2:0] BR_TOP    = 3'd1;
    localparam logic [2:0] BR_RIGHT  = 3'd2;
    localparam logic [2:0] BR_BOTTOM = 3'd3;
    localparam logic [2:0] BR_SAMPLE = 3'd4;
    localparam logic [2:0] BR_PLANE  = 3'd5;

    function automatic logic [6:0] f_paddr(input logic [3:0] rr, input logic [3:0] cc);
        f_paddr = {rr, 3'b000} + {2'b00, rr, 1'b0} + {3'b000, cc};
    endfunction

    logic [15:0] plane_mem [PLANE_SIZE];
    logic [7:0]  sample_mem [64];
    logic [15:0] patch_mem [100];

    logic [7:0]  r_width, r_height;
    logic        r_mode;
    logic [3:0]  r_bx, r_by;
    logic [7:0]  r_rx, r_ry;
    logic [3:0]  r_i, r_j;
    logic [1:0]  r_tap;
    logic [AW-1:0] r_cnt;
    logic        r_uphase;
    logic [7:0]  r_ux, r_uy;
    logic signed [20:0] r_acc;
    logic [15:0] r_prod;
    logic [7:0]  r_px;
    logic [15:0] r_pdata, r_qdata;
    logic [7:0]  r_sdata;
    logic        r_ovalid;
    logic [15:0] r_oraw;
    logic [7:0]  r_obyte;

    logic [7:0]  w_eff_w, w_eff_h, w_wm1, w_hm1, w_rx, w_ry;
    logic [7:0]  w_cx, w_cy;
    logic [PW-1:0] w_asum;
    logic [AW-1:0] w_paddr;
    logic        w_pwe;
    logic [15:0] w_pwdata;
    logic        w_d_in;
    logic [3:0]  w_jj, w_ii;
    logic [9:0]  w_x0, w_y0;
    logic [7:0]  w_x1, w_y1;
    logic [2:0]  w_br;
    logic [6:0]  w_k, w_rep_addr, w_qaddr;
    logic [15:0] w_fval;
    logic [7:0]  w_xmin, w_ymin, w_xmax, w_ymax;
    logic [8:0]  w_xend, w_yend;
    logic [7:0]  w_row8, w_col8;
    logic [3:0]  w_rr, w_cc;
    logic [20:0] w_p21, w_q21, w_fterm, w_uterm;
    logic [16:0] w_bsum;
    logic        w_accept;

    assign w_accept = (i_cmd.op == OP_ACCEPT);

    // effective image size
    always_comb begin
        w_eff_w = r_width;
        if (r_width == 8'd0) begin
            w_eff_w = 8'd1;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff_w = 8'(MAX_WIDTH);
        end
        w_eff_h = r_height;
        if (r_height == 8'd0) begin
            w_eff_h = 8'd1;
        end else if (32'(r_height) > MAX_HEIGHT) begin
            w_eff_h = 8'(MAX_HEIGHT);
        end
    end
    assign w_wm1 = w_eff_w - 8'd1;
    assign w_hm1 = w_eff_h - 8'd1;
    assign w_rx  = (r_rx > w_wm1) ? w_wm1 : r_rx;
    assign w_ry  = (r_ry > w_hm1) ? w_hm1 : r_ry;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 8'd128;
            r_height <= 8'd128;
            r_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_MODE:   r_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // patch build coordinates: rows and columns 0..7 in block, 8 after, 9 before
    assign w_jj = (r_j < 4'd9) ? r_j + 4'd1 : 4'd0;
    assign w_ii = (r_i < 4'd9) ? r_i + 4'd1 : 4'd0;
    assign w_x0 = {2'b00, r_bx, 4'b0000} + ((r_i < 4'd9) ? {5'b0, r_i, 1'b0} : 10'h3FE);
    assign w_y0 = {2'b00, r_by, 4'b0000} + ((r_j < 4'd9) ? {5'b0, r_j, 1'b0} : 10'h3FE);
    assign w_x1 = (w_x0[7:0] != 8'd0) ? w_x0[7:0] - 8'd1 : 8'd0;
    assign w_y1 = (w_y0[7:0] != 8'd0) ? w_y0[7:0] - 8'd1 : 8'd0;
    assign w_k  = f_paddr(w_jj, w_ii);

    // pick the patch entry source, edges replicate earlier entries
    always_comb begin
        if (w_x0[9]) begin
            w_br = BR_LEFT;
        end else if (w_y0[9]) begin
            w_br = BR_TOP;
        end else if (w_x0[8:0] >= {1'b0, w_eff_w}) begin
            w_br = BR_RIGHT;
        end else if (w_y0[8:0] >= {1'b0, w_eff_h}) begin
            w_br = BR_BOTTOM;
        end else if (r_i < 4'd8 && r_j < 4'd8) begin
            w_br = BR_SAMPLE;
        end else begin
            w_br = BR_PLANE;
        end
    end

    always_comb begin
        case (w_br)
            BR_LEFT:   w_rep_addr = f_paddr(w_jj, w_ii + 4'd1);
            BR_TOP:    w_rep_addr = f_paddr(w_jj + 4'd1, w_ii);
            BR_RIGHT:  w_rep_addr = f_paddr(w_jj, w_ii - 4'd1);
            BR_BOTTOM: w_rep_addr = f_paddr(w_jj - 4'd1, w_ii);
            default:   w_rep_addr = w_k;
        endcase
        case (w_br)
            BR_SAMPLE: w_fval = {4'b0000, r_sdata, 4'b0000};
            BR_PLANE:  w_fval = r_acc[17:2];
            default:   w_fval = r_qdata;
        endcase
    end

    // upsample window and patch taps
    assign w_xmin = (r_bx == 4'd0) ? 8'd0 : {r_bx, 4'b0000} - 8'd1;
    assign w_ymin = (r_by == 4'd0) ? 8'd0 : {r_by, 4'b0000} - 8'd1;
    assign w_xend = {1'b0, r_bx, 4'b0000} + 9'd16;
    assign w_yend = {1'b0, r_by, 4'b0000} + 9'd16;
    assign w_xmax = (w_xend > {1'b0, w_wm1}) ? w_wm1 : w_xend[7:0];
    assign w_ymax = (w_yend > {1'b0, w_hm1}) ? w_hm1 : w_yend[7:0];
    assign w_row8 = {1'b0, r_uy[7:1]} + 8'd1 - {1'b0, r_by, 3'b000};
    assign w_col8 = {1'b0, r_ux[7:1]} + 8'd1 - {1'b0, r_bx, 3'b000};

    always_comb begin
        w_rr = w_row8[3:0];
        w_cc = w_col8[3:0];
        if (r_tap == 2'd1 || r_tap == 2'd3) begin
            w_rr = r_uy[0] ? w_row8[3:0] + 4'd1 : w_row8[3:0] - 4'd1;
        end
        if (r_tap == 2'd2 || r_tap == 2'd3) begin
            w_cc = r_ux[0] ? w_col8[3:0] + 4'd1 : w_col8[3:0] - 4'd1;
        end
    end
    assign w_qaddr = r_uphase ? f_paddr(w_rr, w_cc) : w_rep_addr;

    // weighted taps: 9 1 -3 -3 for border rebuild, 9 3 3 1 for upsampling
    assign w_p21 = {5'b0, r_pdata};
    assign w_q21 = {5'b0, r_qdata};
    always_comb begin
        case (r_tap)
            2'd0:    w_fterm = (w_p21 << 3) + w_p21;
            2'd1:    w_fterm = w_p21;
            default: w_fterm = 21'd0 - ((w_p21 << 1) + w_p21);
        endcase
        case (r_tap)
            2'd0:    w_uterm = (w_q21 << 3) + w_q21;
            2'd3:    w_uterm = w_q21;
            default: w_uterm = (w_q21 << 1) + w_q21;
        endcase
    end

    // multiplier operand select
    always_comb begin
        unique case (i_cmd.csel)
            CS_READ: begin
                w_cx = w_rx;
                w_cy = w_ry;
            end
            CS_DIRECT: begin
                w_cx = {1'b0, r_bx, r_i[2:0]};
                w_cy = {1'b0, r_by, r_j[2:0]};
            end
            CS_TAP: begin
                w_cx = (r_tap == 2'd1 || r_tap == 2'd2) ? w_x1 : w_x0[7:0];
                w_cy = (r_tap == 2'd1 || r_tap == 2'd3) ? w_y1 : w_y0[7:0];
            end
            default: begin
                w_cx = r_ux;
                w_cy = r_uy;
            end
        endcase
    end

    assign w_asum = PW'(r_prod) + PW'(r_px);
    assign w_d_in = ({1'b0, r_bx, r_i[2:0]} < w_eff_w) && ({1'b0, r_by, r_j[2:0]} < w_eff_h);

    // plane port: one access per cycle
    always_comb begin
        w_paddr  = w_asum[AW-1:0];
        w_pwe    = 1'b0;
        w_pwdata = r_acc[19:4];
        case (i_cmd.op)
            OP_CLR: begin
                w_paddr  = r_cnt;
                w_pwe    = 1'b1;
                w_pwdata = CLEAR_VALUE;
            end
            OP_D_WR: begin
                w_pwe    = w_d_in;
                w_pwdata = {4'b0000, r_sdata, 4'b0000};
            end
            OP_U_WR: w_pwe = 1'b1;
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            plane_mem[w_paddr] <= w_pwdata;
        end
        r_pdata <= plane_mem[w_paddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_item.kind == K_LOAD) begin
            sample_mem[i_item.sample_index] <= i_item.sample_value;
        end
        r_sdata <= sample_mem[{r_j[2:0], r_i[2:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_F_WR) begin
            patch_mem[w_k] <= w_fval;
        end
        r_qdata <= patch_mem[w_qaddr];
    end

    // address multiplier, item fields and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_MUL) begin
            r_prod <= 16'(w_cy) * 16'(w_eff_w);
            r_px   <= w_cx;
        end
        if (w_accept) begin
            r_bx <= i_item.block_col;
            r_by <= i_item.block_row;
            r_rx <= i_item.read_x;
            r_ry <= i_item.read_y;
        end
        if (i_cmd.op == OP_F_ACC) begin
            r_acc <= ((r_tap == 2'd0) ? 21'sd0 : r_acc) + $signed(w_fterm);
        end else if (i_cmd.op == OP_U_ACC) begin
            r_acc <= ((r_tap == 2'd0) ? 21'sd0 : r_acc) + $signed(w_uterm);
        end
    end

    // loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_j      <= '0;
            r_tap    <= '0;
            r_cnt    <= '0;
            r_uphase <= 1'b0;
            r_ux     <= '0;
            r_uy     <= '0;
        end else begin
            case (i_cmd.op)
                OP_ACCEPT: begin
                    r_i      <= '0;
                    r_j      <= '0;
                    r_tap    <= '0;
                    r_cnt    <= '0;
                    r_uphase <= 1'b0;
                end
                OP_CLR: r_cnt <= r_cnt + AW'(1);
                OP_D_WR: begin
                    r_i <= (r_i[2:0] == 3'd7) ? 4'd0 : r_i + 4'd1;
                    if (r_i[2:0] == 3'd7) begin
                        r_j <= r_j + 4'd1;
                    end
                end
                OP_F_WR: begin
                    r_i <= (r_i == 4'd9) ? 4'd0 : r_i + 4'd1;
                    if (r_i == 4'd9) begin
                        r_j <= r_j + 4'd1;
                    end
                end
                OP_F_ACC, OP_U_ACC: r_tap <= r_tap + 2'd1;
                OP_U_INIT: begin
                    r_ux     <= w_xmin;
                    r_uy     <= w_ymin;
                    r_uphase <= 1'b1;
                    r_tap    <= '0;
                end
                OP_U_WR: begin
                    r_ux <= (r_ux == w_xmax) ? w_xmin : r_ux + 8'd1;
                    if (r_ux == w_xmax) begin
                        r_uy <= r_uy + 8'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register with dithered byte
    assign w_bsum = {1'b0, r_pdata} + 17'd8 - {16'd0, w_rx[0]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_oraw  <= r_pdata;
            r_obyte <= w_bsum[11:4];
        end
    end

    assign o_result.valid      = r_ovalid;
    assign o_result.pixel_raw  = r_oraw;
    assign o_result.pixel_byte = r_obyte;

    // status toward the controller
    assign o_stat.mode     = r_mode;
    assign o_stat.f_skip   = ({r_bx, 4'b0000} >= w_eff_w) || ({r_by, 4'b0000} >= w_eff_h);
    assign o_stat.f_plane  = (w_br == BR_PLANE);
    assign o_stat.clr_last = (r_cnt == AW'(PLANE_SIZE - 1));
    assign o_stat.d_last   = (r_i[2:0] == 3'd7) && (r_j[2:0] == 3'd7);
    assign o_stat.f_last   = (r_i == 4'd9) && (r_j == 4'd9);
    assign o_stat.u_last   = (r_ux == w_xmax) && (r_uy == w_ymax);
    assign o_stat.tap_last = (r_tap == 2'd3);
    assign o_stat.out_busy = r_ovalid && !o_result.ready;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_OUT) |-> !(r_ovalid && !o_result.ready))
        else $error("result register overwritten while stalled");
    a_patch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_F_WR) |-> (!r_uphase && r_i <= 4'd9 && r_j <= 4'd9))
        else $error("patch build counters out of range");
    a_plane_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pwe && i_cmd.op != OP_CLR) |-> (w_asum < PW'(PLANE_SIZE)))
        else $error("plane write address beyond the plane");
`endif

endmodule

/* sv/psfu_ctrl.sv */
// ----------------------------------------------------------------------------
// psfu_ctrl
// Sequencer: accepts items and steps the datapath through each operation.
// ----------------------------------------------------------------------------
module psfu_ctrl
    import psfu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_kind,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_RD_MUL = 5'd2;
    localparam logic [4:0] S_RD_MEM = 5'd3;
    localparam logic [4:0] S_RD_OUT = 5'd4;
    localparam logic [4:0] S_D_MUL  = 5'd5;
    localparam logic [4:0] S_D_WR   = 5'd6;
    localparam logic [4:0] S_F_CHK  = 5'd7;
    localparam logic [4:0] S_F_SEL  = 5'd8;
    localparam logic [4:0] S_F_MUL  = 5'd9;
    localparam logic [4:0] S_F_RD   = 5'd10;
    localparam logic [4:0] S_F_ACC  = 5'd11;
    localparam logic [4:0] S_F_WR   = 5'd12;
    localparam logic [4:0] S_U_INIT = 5'd13;
    localparam logic [4:0] S_U_RD   = 5'd14;
    localparam logic [4:0] S_U_ACC  = 5'd15;
    localparam logic [4:0] S_U_MUL  = 5'd16;
    localparam logic [4:0] S_U_WR   = 5'd17;

    logic [4:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // next state and datapath command
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.csel = CS_READ;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    unique case (i_in_kind)
                        K_LOAD:  n_state = S_IDLE;
                        K_APPLY: n_state = i_stat.mode ? S_F_CHK : S_D_MUL;
                        K_READ:  n_state = S_RD_MUL;
                        default: n_state = S_CLR;
                    endcase
                end
            end
            S_RD_MUL: begin
                o_cmd.op   = OP_MUL;
                o_cmd.csel = CS_READ;
                n_state    = S_RD_MEM;
            end
            S_RD_MEM: n_state = S_RD_OUT;
            S_RD_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            S_D_MUL: begin
                o_cmd.op   = OP_MUL;
                o_cmd.csel = CS_DIRECT;
                n_state    = S_D_WR;
            end
            S_D_WR: begin
                o_cmd.op = OP_D_WR;
                n_state  = i_stat.d_last ? S_IDLE : S_D_MUL;
            end
            S_F_CHK: n_state = i_stat.f_skip ? S_IDLE : S_F_SEL;
            S_F_SEL: n_state = i_stat.f_plane ? S_F_MUL : S_F_WR;
            S_F_MUL: begin
                o_cmd.op   = OP_MUL;
                o_cmd.csel = CS_TAP;
                n_state    = S_F_RD;
            end
            S_F_RD: n_state = S_F_ACC;
            S_F_ACC: begin
                o_cmd.op = OP_F_ACC;
                n_state  = i_stat.tap_last ? S_F_WR : S_F_MUL;
            end
            S_F_WR: begin
                o_cmd.op = OP_F_WR;
                n_state  = i_stat.f_last ? S_U_INIT : S_F_SEL;
            end
            S_U_INIT: begin
                o_cmd.op = OP_U_INIT;
                n_state  = S_U_RD;
            end
            S_U_RD: n_state = S_U_ACC;
            S_U_ACC: begin
                o_cmd.op = OP_U_ACC;
                n_state  = i_stat.tap_last ? S_U_MUL : S_U_RD;
            end
            S_U_MUL: begin
                o_cmd.op   = OP_MUL;
                o_cmd.csel = CS_UP;
                n_state    = S_U_WR;
            end
            S_U_WR: begin
                o_cmd.op = OP_U_WR;
                n_state  = i_stat.u_last ? S_IDLE : S_U_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* tb/psfu_checker.sv */
// ----------------------------------------------------------------------------
// psfu_checker
// Watches the configuration port and both channels of the pixel store, keeps
// its own copy of the plane, and checks every read result against it.
// ----------------------------------------------------------------------------
module psfu_checker
    import psfu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    psfu_item_if       i_item,
    psfu_result_if     i_result,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLANE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int PATCH      = 10;

    typedef struct {
        logic [15:0] raw;
        logic [7:0]  pbyte;
    } t_pixel;

    logic [15:0] plane [PLANE_SIZE];
    logic [7:0]  samples [64];
    logic [15:0] patch [PATCH*PATCH];
    logic [7:0]  width_reg, height_reg;
    logic        mode_reg;
    t_pixel      pixel_q [$];

    function automatic int clamp_dim(logic [7:0] v, int mx);
        if (v == 0) return 1;
        if (int'(v) > mx) return mx;
        return int'(v);
    endfunction

    function automatic int addr(int x, int y, int w);
        return (y * w + x) % PLANE_SIZE;
    endfunction

    function automatic void fill_plane();
        foreach (plane[i]) plane[i] = CLEAR_VALUE;
    endfunction

    // 1x1: one sample per pixel, drop what falls outside the image
    function automatic void write_direct(int bx, int by, int w, int h);
        int x, y;
        for (int iy = 0; iy < 8; iy++) begin
            for (int ix = 0; ix < 8; ix++) begin
                x = 8 * bx + ix;
                y = 8 * by + iy;
                if (x < w && y < h)
                    plane[addr(x, y, w)] = {4'd0, samples[8*iy+ix], 4'd0};
            end
        end
    endfunction

    // 2x2: build the subsampled patch, then run the 9-3-3-1 filter over it
    function automatic void write_fancy(int bx, int by, int w, int h);
        int y0, x0, k, x1, y1, rw, dy, cl, dx, xmin, xmax, ymin, ymax;
        int signed s;
        logic [31:0] su;
        logic [15:0] v;
        if (16 * bx >= w || 16 * by >= h) return;
        for (int j = 0; j < PATCH; j++) begin
            y0 = by * 16 + (j < 9 ? j * 2 : -2);
            for (int i = 0; i < PATCH; i++) begin
                k  = (j < 9 ? (j + 1) * PATCH : 0) + (i < 9 ? i + 1 : 0);
                x0 = bx * 16 + (i < 9 ? i * 2 : -2);
                if (x0 < 0)           v = patch[k+1];
                else if (y0 < 0)      v = patch[k+PATCH];
                else if (x0 >= w)     v = patch[k-1];
                else if (y0 >= h)     v = patch[k-PATCH];
                else if (i < 8 && j < 8) v = {4'd0, samples[j*8+i], 4'd0};
                else begin
                    // invert the upsampler from stored pixels
                    y1 = y0 > 0 ? y0 - 1 : 0;
                    x1 = x0 > 0 ? x0 - 1 : 0;
                    s  = 9 * int'(plane[addr(x0, y0, w)])
                       + int'(plane[addr(x1, y1, w)])
                       - 3 * int'(plane[addr(x1, y0, w)])
                       - 3 * int'(plane[addr(x0, y1, w)]);
                    su = s;
                    v  = su[17:2];
                end
                patch[k] = v;
            end
        end
        xmin = bx * 16 - 1; if (xmin < 0) xmin = 0;
        xmax = bx * 16 + 16; if (xmax > w - 1) xmax = w - 1;
        ymin = by * 16 - 1; if (ymin < 0) ymin = 0;
        ymax = by * 16 + 16; if (ymax > h - 1) ymax = h - 1;
        for (int y = ymin; y <= ymax; y++) begin
            rw = ((y >> 1) - by * 8 + 1) * PATCH;
            dy = ((y & 1) * 2 - 1) * PATCH;
            for (int x = xmin; x <= xmax; x++) begin
                cl = (x >> 1) - bx * 8 + 1;
                dx = (x & 1) * 2 - 1;
                k  = rw + cl;
                su = 9 * patch[k] + 3 * patch[k+dy] + 3 * patch[k+dx] + patch[k+dx+dy];
                plane[addr(x, y, w)] = su[19:4];
            end
        end
    endfunction

    function automatic t_pixel read_pixel(logic [7:0] rx, logic [7:0] ry, int w, int h);
        int x, y;
        t_pixel p;
        logic [16:0] t;
        x = rx; y = ry;
        if (x > w - 1) x = w - 1;
        if (y > h - 1) y = h - 1;
        p.raw   = plane[addr(x, y, w)];
        t       = {1'b0, p.raw} + 17'd8 - 17'(x & 1);
        p.pbyte = t[11:4];
        return p;
    endfunction

    assign o_pending = pixel_q.size();

    always @(posedge i_clk) begin
        int w, h;
        t_pixel exp_px;
        if (!i_rst_n) begin
            fill_plane();
            foreach (samples[i]) samples[i] = '0;
            foreach (patch[i]) patch[i] = '0;
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            mode_reg   <= 1'b0;
            pixel_q.delete();
            o_errors  <= 0;
            o_checked <= 0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  width_reg  <= i_cfg_data;
                    CFG_HEIGHT: height_reg <= i_cfg_data;
                    CFG_MODE:   mode_reg   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // advance the plane copy on every accepted item beat
            w = clamp_dim(width_reg, MAX_WIDTH);
            h = clamp_dim(height_reg, MAX_HEIGHT);
            if (i_item.valid && i_item.ready) begin
                case (i_item.kind)
                    K_LOAD:  samples[i_item.sample_index] = i_item.sample_value;
                    K_APPLY: begin
                        if (mode_reg) write_fancy(i_item.block_col, i_item.block_row, w, h);
                        else          write_direct(i_item.block_col, i_item.block_row, w, h);
                    end
                    K_READ:  pixel_q.push_back(read_pixel(i_item.read_x, i_item.read_y, w, h));
                    K_CLEAR: fill_plane();
                endcase
            end
            // compare each result beat with the oldest expected pixel
            if (i_result.valid && i_result.ready) begin
                o_checked <= o_checked + 1;
                if (pixel_q.size() == 0) begin
                    $error("unexpected result beat: pixel_raw %0d", i_result.pixel_raw);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_px = pixel_q.pop_front();
                    if (i_result.pixel_raw !== exp_px.raw ||
                        i_result.pixel_byte !== exp_px.pbyte)
                        o_errors <= o_errors + 1;
                    if (i_result.pixel_raw !== exp_px.raw)
                        $error("pixel_raw: expected %0d, got %0d",
                               exp_px.raw, i_result.pixel_raw);
                    if (i_result.pixel_byte !== exp_px.pbyte)
                        $error("pixel_byte: expected %0d, got %0d",
                               exp_px.pbyte, i_result.pixel_byte);
                end
            end
        end
    end

endmodule

/* tb/block_pixel_store_fancy_upsample_unit_tb.sv */
// ----------------------------------------------------------------------------
// block_pixel_store_fancy_upsample_unit_tb
// Drives sample loads, block applies in both modes, reads and clears through
// several image sizes; the checker module predicts and compares every read.
// ----------------------------------------------------------------------------
module block_pixel_store_fancy_upsample_unit_tb;
    import psfu_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 100000;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    int         errors, pending, checked;
    int         items_sent, phases, idle_cycles;
    bit         quiet;
    int         stall_left;
    int         cur_w, cur_h;
    bit         cur_mode;

    psfu_item_if   item_ch ();
    psfu_result_if result_ch ();

    block_pixel_store_fancy_upsample_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    psfu_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_ch),
        .i_result    (result_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall bursts, none once the run goes quiet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            result_ch.ready <= (stall_left == 1);
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 5);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(logic [1:0] kind, logic [5:0] idx, logic [7:0] val,
                        logic [3:0] bc, logic [3:0] br, logic [7:0] rx, logic [7:0] ry);
        // insert a sender gap now and then
        if (!quiet && $urandom_range(0, 5) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= kind;
        item_ch.sample_index <= idx;
        item_ch.sample_value <= val;
        item_ch.block_col    <= bc;
        item_ch.block_row    <= br;
        item_ch.read_x       <= rx;
        item_ch.read_y       <= ry;
        // ready is stable by the falling edge; the beat lands on the next rising one
        forever begin
            @(negedge i_clk);
            if (item_ch.ready) break;
        end
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_read(logic [7:0] rx, logic [7:0] ry);
        send(K_READ, $urandom, $urandom, $urandom, $urandom, rx, ry);
    endtask

    task automatic random_read();
        if ($urandom_range(0, 9) < 6)
            send_read($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
        else
            send_read($urandom, $urandom);
    endtask

    // close a phase: finish with a read, hold until all results are back
    task automatic drain();
        random_read();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(logic [7:0] w, logic [7:0] h, logic [7:0] m);
        cfg_we <= 1'b1; cfg_index <= CFG_WIDTH;  cfg_data <= w; @(posedge i_clk);
        cfg_index <= CFG_HEIGHT; cfg_data <= h; @(posedge i_clk);
        cfg_index <= CFG_MODE;   cfg_data <= m; @(posedge i_clk);
        cfg_we <= 1'b0;
        cur_w = (w == 0) ? 1 : (w > 128 ? 128 : w);
        cur_h = (h == 0) ? 1 : (h > 128 ? 128 : h);
        cur_mode = m[0];
        phases++;
    endtask

    // random mix: mostly load-then-apply sequences followed by reads
    task automatic run_mix(int count);
        int stop, nload, lim_c, lim_r;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(0, 99) < 65) begin
                if ($urandom_range(0, 1) == 0) begin
                    for (int i = 0; i < 64; i++) send(K_LOAD, i, $urandom, $urandom,
                                                      $urandom, $urandom, $urandom);
                end else begin
                    nload = $urandom_range(1, 20);
                    repeat (nload) send(K_LOAD, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom);
                end
                lim_c = cur_mode ? (cur_w - 1) >> 4 : (cur_w - 1) >> 3;
                lim_r = cur_mode ? (cur_h - 1) >> 4 : (cur_h - 1) >> 3;
                if (lim_c > 15) lim_c = 15;
                if (lim_r > 15) lim_r = 15;
                if ($urandom_range(0, 4) == 0)
                    send(K_APPLY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    send(K_APPLY, $urandom, $urandom, $urandom_range(0, lim_c),
                         $urandom_range(0, lim_r), $urandom, $urandom);
                repeat ($urandom_range(2, 6)) random_read();
            end else if ($urandom_range(0, 39) == 0) begin
                send(K_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                random_read();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_WIDTH; cfg_data = '0;
        item_ch.valid = 1'b0; item_ch.kind = K_LOAD; item_ch.sample_index = '0;
        item_ch.sample_value = '0; item_ch.block_col = '0; item_ch.block_row = '0;
        item_ch.read_x = '0; item_ch.read_y = '0;
        quiet = 1'b0; items_sent = 0; phases = 0;
        cur_w = 128; cur_h = 128; cur_mode = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: cleared plane, clamped reads, extreme samples, edge blocks
        send_read(8'd0, 8'd0);
        send_read(8'd255, 8'd255);
        for (int i = 0; i < 64; i++)
            send(K_LOAD, i, (i & 1) ? 8'hFF : 8'h00, '0, '0, '0, '0);
        send(K_APPLY, '0, '0, 4'd0, 4'd0, '0, '0);
        send(K_APPLY, '0, '0, 4'd15, 4'd15, '0, '0);
        send_read(8'd1, 8'd0);
        send_read(8'd127, 8'd127);
        drain();

        set_config(8'd40, 8'd24, 8'd1);
        send(K_APPLY, '0, '0, 4'd0, 4'd0, '0, '0);
        send(K_APPLY, '0, '0, 4'd2, 4'd1, '0, '0);
        send(K_APPLY, '0, '0, 4'd3, 4'd0, '0, '0);
        send_read(8'd17, 8'd16);
        send_read(8'd255, 8'd0);
        send(K_CLEAR, '0, '0, '0, '0, '0, '0);
        send_read(8'd39, 8'd23);
        drain();

        // random phases over a spread of sizes, extremes included
        set_config(8'd128, 8'd128, 8'd1);  run_mix(250); drain();
        set_config(8'd0, 8'd0, 8'd255);    run_mix(120); drain();
        set_config(8'd255, 8'd17, 8'hFE);  run_mix(250); drain();
        set_config(8'd1, 8'd128, 8'd1);    run_mix(150); drain();
        set_config(8'd37, 8'd90, 8'd1);    run_mix(300); drain();
        set_config(8'd100, 8'd50, 8'd0);   run_mix(250); drain();
        quiet = 1'b1;
        set_config(8'd66, 8'd33, 8'd1);    run_mix(250); drain();

        repeat (50) @(posedge i_clk);
        $display("Covered %0d item beats over %0d register settings, %0d reads checked.",
                 items_sent, phases, checked);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
